// ----- sv/tfs_pkg.sv -----
// Shared types and constants for the triangle flat-shade setup pipeline.
// No dependencies; every other file imports this package.
package tfs_pkg;

  localparam int COORD_FRAC_BITS = 14;
  localparam int MAX_SCREEN_DIM  = 4096;
  localparam int MAX_DEPTH_SPAN  = 65536;

  // Cycles from an accepted request to its done strobe being sampled.
  localparam int PIPE_LATENCY = 18;
  // Extra delay that lines the screen coordinates up with the shade result.
  localparam int COORD_DELAY  = 14;

  // Widths of the shade square-root datapath.
  localparam int TSQ_W  = 116;
  localparam int PNN_W  = 96;
  localparam int ROOT_W = 120;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_DEPTH_SPAN    = 3'd2,
    REG_LIGHT_X       = 3'd3,
    REG_LIGHT_Y       = 3'd4,
    REG_LIGHT_Z       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } tri_t;

  typedef struct packed {
    logic [11:0] sx;
    logic [11:0] sy;
    logic [15:0] sz;
  } scr_vtx_t;

  typedef struct packed {
    scr_vtx_t a;
    scr_vtx_t b;
    scr_vtx_t c;
  } scr_tri_t;

  // Viewport extents minus one, already clamped to their legal range.
  typedef struct packed {
    logic [11:0] xm1;
    logic [11:0] ym1;
    logic [15:0] zm1;
  } dims_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } light_t;

  // Request handed from the normal stages to the shade root stages.
  typedef struct packed {
    logic             pos;
    logic [TSQ_W-1:0] tsq;
    logic [PNN_W-1:0] pnn;
  } root_req_t;

endpackage

// ----- sv/tfs_viewport.sv -----
// Two-stage viewport transform of the nine vertex coordinates.
// Depends on tfs_pkg.
module tfs_viewport (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tfs_pkg::tri_t     tri_i,
  input  tfs_pkg::dims_t    dims_i,
  output logic              valid_o,
  output tfs_pkg::scr_tri_t scr_o
);
  import tfs_pkg::*;

  logic signed [15:0] crd[9];
  logic [15:0]        dm[3];
  logic signed [33:0] prod_d[9];
  logic signed [33:0] prod_q[9];
  logic [15:0]        dmq_q[3];
  logic [15:0]        res_d[9];
  logic [15:0]        res_q[9];
  logic               v1_q, v2_q;

  assign crd[0] = tri_i.a.x; assign crd[1] = tri_i.a.y; assign crd[2] = tri_i.a.z;
  assign crd[3] = tri_i.b.x; assign crd[4] = tri_i.b.y; assign crd[5] = tri_i.b.z;
  assign crd[6] = tri_i.c.x; assign crd[7] = tri_i.c.y; assign crd[8] = tri_i.c.z;
  assign dm[0] = 16'(dims_i.xm1);
  assign dm[1] = 16'(dims_i.ym1);
  assign dm[2] = dims_i.zm1;

  // Stage one: offset each coordinate by one and scale by the extent.
  always_comb begin
    logic signed [16:0] off;
    for (int i = 0; i < 9; i++) begin
      off = 17'(crd[i]) + 17'sd16384;
      prod_d[i] = 34'(off) * 34'(signed'({1'b0, dm[i % 3]}));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) prod_q[i] <= prod_d[i];
    for (int j = 0; j < 3; j++) dmq_q[j] <= dm[j];
  end

  // Stage two: halve and saturate to the screen.
  always_comb begin
    logic [18:0] q;
    for (int i = 0; i < 9; i++) begin
      q = prod_q[i][33:COORD_FRAC_BITS+1];
      if (prod_q[i][33]) begin
        res_d[i] = '0;
      end else if (q > {3'b0, dmq_q[i % 3]}) begin
        res_d[i] = dmq_q[i % 3];
      end else begin
        res_d[i] = q[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) res_q[i] <= res_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o  = v2_q;
  assign scr_o.a.sx = res_q[0][11:0];
  assign scr_o.a.sy = res_q[1][11:0];
  assign scr_o.a.sz = res_q[2];
  assign scr_o.b.sx = res_q[3][11:0];
  assign scr_o.b.sy = res_q[4][11:0];
  assign scr_o.b.sz = res_q[5];
  assign scr_o.c.sx = res_q[6][11:0];
  assign scr_o.c.sy = res_q[7][11:0];
  assign scr_o.c.sz = res_q[8];

endmodule

// ----- sv/tfs_normal.sv -----
// Eight-stage face normal, light dot product and squared terms for shading.
// Depends on tfs_pkg.
module tfs_normal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tfs_pkg::tri_t      tri_i,
  input  tfs_pkg::light_t    light_i,
  output logic               valid_o,
  output tfs_pkg::root_req_t req_o
);
  import tfs_pkg::*;

  logic [7:0] v_q;

  logic signed [16:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [33:0] m_q[6];
  logic signed [34:0] nx_q, ny_q, nz_q;
  logic signed [50:0] pd_q[3];
  logic [33:0]        an_q[3];
  logic signed [52:0] d_q;
  logic [33:0]        hh_q[3], hl_q[3], ll_q[3];
  logic [67:0]        sq_q[3];
  logic [57:0]        t_q;
  logic               pos6_q, pos7_q, pos8_q;
  logic [67:0]        nn_q;
  logic [57:0]        th2_q, thl_q, tl2_q;
  logic [TSQ_W-1:0]   tsq_q;
  logic [PNN_W-1:0]   pnn_q;

  // Stage one: edge vectors.
  always_ff @(posedge clk_i) begin
    e1x_q <= 17'(tri_i.c.x) - 17'(tri_i.a.x);
    e1y_q <= 17'(tri_i.c.y) - 17'(tri_i.a.y);
    e1z_q <= 17'(tri_i.c.z) - 17'(tri_i.a.z);
    e2x_q <= 17'(tri_i.b.x) - 17'(tri_i.a.x);
    e2y_q <= 17'(tri_i.b.y) - 17'(tri_i.a.y);
    e2z_q <= 17'(tri_i.b.z) - 17'(tri_i.a.z);
  end

  // Stage two: cross product partial products.
  always_ff @(posedge clk_i) begin
    m_q[0] <= 34'(e1y_q) * 34'(e2z_q);
    m_q[1] <= 34'(e1z_q) * 34'(e2y_q);
    m_q[2] <= 34'(e1z_q) * 34'(e2x_q);
    m_q[3] <= 34'(e1x_q) * 34'(e2z_q);
    m_q[4] <= 34'(e1x_q) * 34'(e2y_q);
    m_q[5] <= 34'(e1y_q) * 34'(e2x_q);
  end

  // Stage three: normal components.
  always_ff @(posedge clk_i) begin
    nx_q <= 35'(m_q[0]) - 35'(m_q[1]);
    ny_q <= 35'(m_q[2]) - 35'(m_q[3]);
    nz_q <= 35'(m_q[4]) - 35'(m_q[5]);
  end

  // Stage four: light products and normal magnitudes per component.
  always_ff @(posedge clk_i) begin
    pd_q[0] <= 51'(nx_q) * 51'(light_i.x);
    pd_q[1] <= 51'(ny_q) * 51'(light_i.y);
    pd_q[2] <= 51'(nz_q) * 51'(light_i.z);
    an_q[0] <= 34'(nx_q[34] ? -nx_q : nx_q);
    an_q[1] <= 34'(ny_q[34] ? -ny_q : ny_q);
    an_q[2] <= 34'(nz_q[34] ? -nz_q : nz_q);
  end

  // Stage five: dot product sum and split squares of the magnitudes.
  always_ff @(posedge clk_i) begin
    d_q <= 53'(pd_q[0]) + 53'(pd_q[1]) + 53'(pd_q[2]);
    for (int i = 0; i < 3; i++) begin
      hh_q[i] <= 34'(an_q[i][33:17]) * 34'(an_q[i][33:17]);
      hl_q[i] <= 34'(an_q[i][33:17]) * 34'(an_q[i][16:0]);
      ll_q[i] <= 34'(an_q[i][16:0]) * 34'(an_q[i][16:0]);
    end
  end

  // Stage six: full squares, sign test and scaled dot product.
  // The cross term appears twice, hence one extra bit of shift.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= {hh_q[i], 34'b0} + {16'b0, hl_q[i], 18'b0} + {34'b0, ll_q[i]};
    end
    t_q    <= {d_q[49:0], 8'b0} - 58'(d_q);
    pos6_q <= !d_q[52] && (d_q != '0);
  end

  // Stage seven: squared normal length and split square of the scaled dot.
  always_ff @(posedge clk_i) begin
    nn_q   <= sq_q[0] + sq_q[1] + sq_q[2];
    th2_q  <= 58'(t_q[57:29]) * 58'(t_q[57:29]);
    thl_q  <= 58'(t_q[57:29]) * 58'(t_q[28:0]);
    tl2_q  <= 58'(t_q[28:0]) * 58'(t_q[28:0]);
    pos7_q <= pos6_q;
  end

  // Stage eight: assemble the two sides of the shade comparison.
  always_ff @(posedge clk_i) begin
    tsq_q  <= {th2_q, 58'b0} + {28'b0, thl_q, 30'b0} + {58'b0, tl2_q};
    pnn_q  <= {nn_q, 28'b0};
    pos8_q <= pos7_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  assign valid_o   = v_q[7];
  assign req_o.pos = pos8_q;
  assign req_o.tsq = tsq_q;
  assign req_o.pnn = pnn_q;

endmodule

// ----- sv/tfs_isqrt.sv -----
// Eight-stage bit-per-stage search for the largest shade s with
// s*s*pnn <= tsq. Depends on tfs_pkg.
module tfs_isqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tfs_pkg::root_req_t req_i,
  output logic               valid_o,
  output logic               pos_o,
  output logic [7:0]         shade_o
);
  import tfs_pkg::*;

  logic [ROOT_W-1:0] r_q[8], q_q[8], p_q[8];
  logic [7:0]        s_q[8];
  logic [7:0]        pos_q;
  logic [7:0]        v_q;

  for (genvar j = 0; j < 8; j++) begin : g_stage
    localparam int Bit = 7 - j;
    logic [ROOT_W-1:0] r_in, q_in, p_in, inc;
    logic [7:0]        s_in;
    logic              pos_in;

    if (j == 0) begin : g_first
      assign r_in   = ROOT_W'(req_i.tsq);
      assign q_in   = '0;
      assign p_in   = ROOT_W'(req_i.pnn);
      assign s_in   = '0;
      assign pos_in = req_i.pos;
    end else begin : g_next
      assign r_in   = r_q[j-1];
      assign q_in   = q_q[j-1];
      assign p_in   = p_q[j-1];
      assign s_in   = s_q[j-1];
      assign pos_in = pos_q[j-1];
    end

    // Cost of setting this bit: (2*s*2^k + 2^2k) * pnn.
    assign inc = (q_in << (Bit + 1)) + (p_in << (2 * Bit));

    always_ff @(posedge clk_i) begin
      p_q[j]   <= p_in;
      pos_q[j] <= pos_in;
      if (inc <= r_in) begin
        r_q[j] <= r_in - inc;
        q_q[j] <= q_in + (p_in << Bit);
        s_q[j] <= s_in | 8'(1 << Bit);
      end else begin
        r_q[j] <= r_in;
        q_q[j] <= q_in;
        s_q[j] <= s_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  assign valid_o = v_q[7];
  assign pos_o   = pos_q[7];
  assign shade_o = s_q[7];

endmodule

// ----- sv/triangle_flat_shade_setup.sv -----
// Triangle flat-shade setup: viewport transform, face culling and gray shade.
// Throughput one request per cycle; the 8-stage shade root search and the
// 8-stage normal datapath are fully pipelined, so busy_o never rises.
// Reset clears the pipeline valid bits and loads the register reset values.
module triangle_flat_shade_setup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  input  logic signed [15:0] c_x_i,
  input  logic signed [15:0] c_y_i,
  input  logic signed [15:0] c_z_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [16:0]        cfg_wdata_i,
  output logic               done_o,
  output logic [11:0]        a_sx_o,
  output logic [11:0]        a_sy_o,
  output logic [15:0]        a_sz_o,
  output logic [11:0]        b_sx_o,
  output logic [11:0]        b_sy_o,
  output logic [15:0]        b_sz_o,
  output logic [11:0]        c_sx_o,
  output logic [11:0]        c_sy_o,
  output logic [15:0]        c_sz_o,
  output logic               visible_o,
  output logic [7:0]         shade_o
);
  import tfs_pkg::*;

  logic [12:0]  width_q, height_q;
  logic [16:0]  depth_q;
  light_t       light_q;
  dims_t        dims;
  tri_t         in_q;
  logic         in_v_q;
  logic         vp_v, nrm_v, rt_v, rt_pos;
  scr_tri_t     vp_scr;
  root_req_t    nrm_req;
  logic [7:0]   rt_shade;
  scr_tri_t     dly_q[COORD_DELAY];
  scr_tri_t     out_scr_q;
  logic         out_v_q, out_vis_q;
  logic [7:0]   out_shade_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 13'd600;
      height_q  <= 13'd600;
      depth_q   <= 17'd1000;
      light_q.x <= 16'sd0;
      light_q.y <= 16'sd0;
      light_q.z <= -16'sd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCREEN_WIDTH:  width_q   <= cfg_wdata_i[12:0];
        REG_SCREEN_HEIGHT: height_q  <= cfg_wdata_i[12:0];
        REG_DEPTH_SPAN:    depth_q   <= cfg_wdata_i;
        REG_LIGHT_X:       light_q.x <= signed'(cfg_wdata_i[15:0]);
        REG_LIGHT_Y:       light_q.y <= signed'(cfg_wdata_i[15:0]);
        REG_LIGHT_Z:       light_q.z <= signed'(cfg_wdata_i[15:0]);
        default: ;
      endcase
    end
  end

  // Extents minus one, with out-of-range sizes clamped.
  always_comb begin
    if (width_q < 13'd2) dims.xm1 = 12'd1;
    else if (width_q > 13'(MAX_SCREEN_DIM)) dims.xm1 = 12'(MAX_SCREEN_DIM - 1);
    else dims.xm1 = 12'(width_q - 13'd1);
    if (height_q < 13'd2) dims.ym1 = 12'd1;
    else if (height_q > 13'(MAX_SCREEN_DIM)) dims.ym1 = 12'(MAX_SCREEN_DIM - 1);
    else dims.ym1 = 12'(height_q - 13'd1);
    if (depth_q < 17'd2) dims.zm1 = 16'd1;
    else if (depth_q > 17'(MAX_DEPTH_SPAN)) dims.zm1 = 16'(MAX_DEPTH_SPAN - 1);
    else dims.zm1 = 16'(depth_q - 17'd1);
  end

  // Input request register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q.a <= '{a_x_i, a_y_i, a_z_i};
      in_q.b <= '{b_x_i, b_y_i, b_z_i};
      in_q.c <= '{c_x_i, c_y_i, c_z_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start_i;
    end
  end

  assign busy_o = 1'b0;

  tfs_viewport u_viewport (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v_q),
    .tri_i   (in_q),
    .dims_i  (dims),
    .valid_o (vp_v),
    .scr_o   (vp_scr)
  );

  tfs_normal u_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v_q),
    .tri_i   (in_q),
    .light_i (light_q),
    .valid_o (nrm_v),
    .req_o   (nrm_req)
  );

  tfs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nrm_v),
    .req_i   (nrm_req),
    .valid_o (rt_v),
    .pos_o   (rt_pos),
    .shade_o (rt_shade)
  );

  // Screen coordinates wait for the shade result.
  always_ff @(posedge clk_i) begin
    dly_q[0] <= vp_scr;
    for (int i = 1; i < COORD_DELAY; i++) dly_q[i] <= dly_q[i-1];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    out_scr_q   <= dly_q[COORD_DELAY-1];
    out_vis_q   <= rt_pos;
    out_shade_q <= rt_pos ? rt_shade : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= rt_v;
    end
  end

  assign done_o    = out_v_q;
  assign a_sx_o    = out_scr_q.a.sx;
  assign a_sy_o    = out_scr_q.a.sy;
  assign a_sz_o    = out_scr_q.a.sz;
  assign b_sx_o    = out_scr_q.b.sx;
  assign b_sy_o    = out_scr_q.b.sy;
  assign b_sz_o    = out_scr_q.b.sz;
  assign c_sx_o    = out_scr_q.c.sx;
  assign c_sy_o    = out_scr_q.c.sy;
  assign c_sz_o    = out_scr_q.c.sz;
  assign visible_o = out_vis_q;
  assign shade_o   = out_shade_q;

  // Every request produces a result after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(PIPE_LATENCY) done_o)
    else $error("request did not complete after the pipeline latency");

  // No result without a request the pipeline latency earlier.
  a_no_ghost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, PIPE_LATENCY))
    else $error("result without a matching request");

  // The viewport path stays in step with the input register.
  a_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vp_v |-> $past(in_v_q, 2))
    else $error("viewport path out of step with the input register");

  // A culled face carries no shade.
  a_cull_shade : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !visible_o) |-> (shade_o == 8'd0))
    else $error("culled face with nonzero shade");

endmodule
